@@ rtl/lzad_pkg.sv @@
package lzad_pkg;

	localparam int NUM_PROBS = 803;
	localparam int PROB_AW   = 10;
	localparam int PROB_W    = 12;

	localparam logic [PROB_W-1:0] PROB_INIT = 12'd1024;
	localparam logic [PROB_W-1:0] PROB_ONE  = 12'd2048;

	localparam logic [PROB_AW-1:0] M_CODE = 10'd0;
	localparam logic [PROB_AW-1:0] M_PREV = 10'd2;
	localparam logic [PROB_AW-1:0] M_LOW  = 10'd3;
	localparam logic [PROB_AW-1:0] M_LIT  = 10'd35;
	localparam logic [PROB_AW-1:0] M_G0   = 10'd291;
	localparam logic [PROB_AW-1:0] M_G1   = 10'd547;

	localparam logic [31:0] FAR_OFFSET  = 32'd2048;
	localparam logic [31:0] NEAR_OFFSET = 32'd96;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_STARVED = 2'd1;
	localparam logic [1:0] STAT_BAD_OFS = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic       opcode;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       stream_end;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [3:0] {
		PH_PRE0   = 4'd0,
		PH_PRE1   = 4'd1,
		PH_PRE2   = 4'd2,
		PH_PRE3   = 4'd3,
		PH_CODE   = 4'd4,
		PH_LIT    = 4'd5,
		PH_PREV   = 4'd6,
		PH_G0A    = 4'd7,
		PH_G0B    = 4'd8,
		PH_LOW    = 4'd9,
		PH_G1A    = 4'd10,
		PH_G1B    = 4'd11,
		PH_COPY   = 4'd12,
		PH_END    = 4'd13,
		PH_LOWFIN = 4'd14
	} phase_t;

	typedef enum logic [2:0] {
		ACT_PRELOAD,
		ACT_BIT,
		ACT_LOWFIN,
		ACT_COPY,
		ACT_END
	} act_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLR,
		CMD_LATCH,
		CMD_PUSH,
		CMD_FIN_OK,
		CMD_STARVE,
		CMD_PRELOAD,
		CMD_NORM,
		CMD_MUL,
		CMD_UPD,
		CMD_APPLY,
		CMD_LOWFIN,
		CMD_COPY,
		CMD_OUT
	} cmd_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_PUSH,
		S_DISPATCH,
		S_PRELOAD,
		S_NORM,
		S_MUL,
		S_UPD,
		S_APPLY,
		S_COPY,
		S_DONE
	} state_t;

	typedef struct packed {
		cmd_t cmd;
	} ctl_t;

	typedef struct packed {
		logic clr_done;
		logic op_pull;
		act_t act;
		logic need_norm;
		logic fifo_empty;
		logic done;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/lzad_ram.sv @@
module lzad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/lzad_ctrl.sv @@
module lzad_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  lzad_pkg::sts_t sts,
	output lzad_pkg::ctl_t ctl
);

	lzad_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzad_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl.cmd  = lzad_pkg::CMD_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			lzad_pkg::S_CLEAR: begin
				ctl.cmd = lzad_pkg::CMD_CLR;
				if (sts.clr_done) begin
					state_d = lzad_pkg::S_IDLE;
				end
			end
			lzad_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.cmd = lzad_pkg::CMD_LATCH;
					state_d = lzad_pkg::S_DECIDE;
				end
			end
			lzad_pkg::S_DECIDE: begin
				state_d = sts.op_pull ? lzad_pkg::S_DISPATCH : lzad_pkg::S_PUSH;
			end
			lzad_pkg::S_PUSH: begin
				ctl.cmd = lzad_pkg::CMD_PUSH;
				state_d = lzad_pkg::S_DONE;
			end
			lzad_pkg::S_DISPATCH: begin
				if (sts.done) begin
					state_d = lzad_pkg::S_DONE;
				end else begin
					unique case (sts.act)
						lzad_pkg::ACT_END: begin
							ctl.cmd = lzad_pkg::CMD_FIN_OK;
							state_d = lzad_pkg::S_DONE;
						end
						lzad_pkg::ACT_PRELOAD: begin
							if (sts.fifo_empty) begin
								ctl.cmd = lzad_pkg::CMD_STARVE;
								state_d = lzad_pkg::S_DONE;
							end else begin
								state_d = lzad_pkg::S_PRELOAD;
							end
						end
						lzad_pkg::ACT_BIT: begin
							if (!sts.need_norm) begin
								state_d = lzad_pkg::S_MUL;
							end else if (sts.fifo_empty) begin
								// stop at this bit boundary, resume on a later pull
								ctl.cmd = lzad_pkg::CMD_STARVE;
								state_d = lzad_pkg::S_DONE;
							end else begin
								state_d = lzad_pkg::S_NORM;
							end
						end
						lzad_pkg::ACT_LOWFIN: begin
							ctl.cmd = lzad_pkg::CMD_LOWFIN;
						end
						lzad_pkg::ACT_COPY: begin
							state_d = lzad_pkg::S_COPY;
						end
						default: begin
							state_d = lzad_pkg::S_DISPATCH;
						end
					endcase
				end
			end
			lzad_pkg::S_PRELOAD: begin
				ctl.cmd = lzad_pkg::CMD_PRELOAD;
				state_d = lzad_pkg::S_DISPATCH;
			end
			lzad_pkg::S_NORM: begin
				ctl.cmd = lzad_pkg::CMD_NORM;
				state_d = lzad_pkg::S_MUL;
			end
			lzad_pkg::S_MUL: begin
				ctl.cmd = lzad_pkg::CMD_MUL;
				state_d = lzad_pkg::S_UPD;
			end
			lzad_pkg::S_UPD: begin
				ctl.cmd = lzad_pkg::CMD_UPD;
				state_d = lzad_pkg::S_APPLY;
			end
			lzad_pkg::S_APPLY: begin
				ctl.cmd = lzad_pkg::CMD_APPLY;
				state_d = lzad_pkg::S_DISPATCH;
			end
			lzad_pkg::S_COPY: begin
				ctl.cmd = lzad_pkg::CMD_COPY;
				state_d = lzad_pkg::S_DONE;
			end
			lzad_pkg::S_DONE: begin
				if (sts.out_free) begin
					ctl.cmd = lzad_pkg::CMD_OUT;
					state_d = lzad_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lzad_pkg::S_CLEAR;
			end
		endcase
	end

endmodule

@@ rtl/lzad_dp.sv @@
module lzad_dp #(
	parameter int WINDOW_BYTES     = 65536,
	parameter int INPUT_FIFO_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lzad_pkg::ctl_t      ctl,
	output lzad_pkg::sts_t      sts,
	input  lzad_pkg::in_item_t  in_item,
	output logic                res_valid,
	input  logic                res_stall,
	output lzad_pkg::out_item_t res_item
);

	localparam int FA = (INPUT_FIFO_DEPTH > 1) ? $clog2(INPUT_FIFO_DEPTH) : 1;
	localparam int FC = $clog2(INPUT_FIFO_DEPTH + 1);
	localparam int HA = $clog2(WINDOW_BYTES);
	localparam int HF = $clog2(WINDOW_BYTES + 1);
	localparam int PA = lzad_pkg::PROB_AW;
	localparam int PW = lzad_pkg::PROB_W;

	localparam logic [FA-1:0] FIFO_LAST = FA'(INPUT_FIFO_DEPTH - 1);
	localparam logic [FC-1:0] FIFO_FULL = FC'(INPUT_FIFO_DEPTH);
	localparam logic [HA-1:0] WIN_LAST  = HA'(WINDOW_BYTES - 1);
	localparam logic [HF-1:0] WIN_FULL  = HF'(WINDOW_BYTES);
	localparam logic [HA+1:0] WIN_ADD   = (HA+2)'(WINDOW_BYTES);
	localparam logic [PA-1:0] PROB_LAST = PA'(lzad_pkg::NUM_PROBS - 1);
	localparam logic [PA-1:0] PROB_CNT  = PA'(lzad_pkg::NUM_PROBS);

	logic               op_q;
	logic [7:0]         byte_q;
	logic [31:0]        code_q, range_q, bound_q;
	logic               bit_q;
	lzad_pkg::phase_t   phase_q;
	logic [8:0]         tree_q;
	logic [31:0]        gval_q;
	logic [7:0]         gctx_q;
	logic [1:0]         extra_q;
	logic [31:0]        last_q, coff_q, cleft_q;
	logic               after_q;
	logic [HA-1:0]      wpos_q;
	logic [HF-1:0]      fill_q;
	logic [FA-1:0]      rd_q, wr_q;
	logic [FC-1:0]      cnt_q;
	logic [PA-1:0]      clr_q;
	logic               done_q, rvalid_q, ov_q;
	logic [7:0]         rbyte_q;
	logic [1:0]         rstat_q;
	lzad_pkg::out_item_t oitem_q;

	logic [7:0]    f_rd, h_rd;
	logic [PW-1:0] p_rd;

	// probability index for the bit about to be decoded
	logic [PA-1:0] idx_raw, idx;
	always_comb begin
		case (phase_q) inside
			lzad_pkg::PH_CODE: idx_raw = lzad_pkg::M_CODE + PA'(after_q);
			lzad_pkg::PH_LIT:  idx_raw = lzad_pkg::M_LIT + PA'(tree_q);
			lzad_pkg::PH_PREV: idx_raw = lzad_pkg::M_PREV;
			lzad_pkg::PH_G0A, lzad_pkg::PH_G0B: idx_raw = lzad_pkg::M_G0 + PA'(gctx_q);
			lzad_pkg::PH_G1A, lzad_pkg::PH_G1B: idx_raw = lzad_pkg::M_G1 + PA'(gctx_q);
			lzad_pkg::PH_LOW: idx_raw = lzad_pkg::M_LOW + ((coff_q != 32'd0) ? PA'(16) : PA'(0))
				+ PA'(tree_q[3:0]);
			default: idx_raw = '0;
		endcase
		idx = (idx_raw >= PROB_CNT) ? '0 : idx_raw;
	end

	logic [32:0] prod;
	assign prod = range_q[31:11] * p_rd;

	logic          lt;
	logic [PW-1:0] p_gap, p_inc, p_dec;
	logic          lit_shift;
	assign lt        = code_q < bound_q;
	assign lit_shift = (phase_q == lzad_pkg::PH_LIT);
	assign p_gap     = lzad_pkg::PROB_ONE - p_rd;
	assign p_inc     = p_rd + (lit_shift ? (p_gap >> 4) : (p_gap >> 5));
	assign p_dec     = p_rd - (lit_shift ? (p_rd >> 4) : (p_rd >> 5));

	logic [8:0]  lit_t;
	logic [31:0] ngv;
	logic [7:0]  ngc;
	logic [31:0] ncl;
	logic        bad_ofs;
	assign lit_t   = {tree_q[7:0], bit_q};
	assign ngv     = {gval_q[30:0], bit_q};
	assign ngc     = {gctx_q[6:0], bit_q};
	assign ncl     = 32'(extra_q) + ngv;
	assign bad_ofs = (coff_q == 32'd0) || (coff_q > 32'(fill_q));

	logic [31:0] noff;
	logic [1:0]  nextra;
	assign noff   = {coff_q[27:0], 4'b0000} + 32'(tree_q[3:0]) + 32'd1;
	assign nextra = noff[31] ? 2'd0
		: (2'((noff >= lzad_pkg::FAR_OFFSET)) + 2'((noff >= lzad_pkg::NEAR_OFFSET)));

	logic [HA+1:0] hdiff, hsum;
	logic [HA-1:0] h_raddr;
	assign hdiff   = (HA+2)'(wpos_q) - (HA+2)'(coff_q[HA:0]);
	assign hsum    = hdiff[HA+1] ? (hdiff + WIN_ADD) : hdiff;
	assign h_raddr = hsum[HA-1:0];

	logic [FA-1:0] rd_nxt, wr_nxt;
	logic [HA-1:0] wpos_nxt;
	logic [HF-1:0] fill_nxt;
	assign rd_nxt   = (rd_q == FIFO_LAST) ? '0 : rd_q + 1'b1;
	assign wr_nxt   = (wr_q == FIFO_LAST) ? '0 : wr_q + 1'b1;
	assign wpos_nxt = (wpos_q == WIN_LAST) ? '0 : wpos_q + 1'b1;
	assign fill_nxt = (fill_q < WIN_FULL) ? fill_q + 1'b1 : fill_q;

	logic          p_we, h_we, f_we;
	logic [PA-1:0] p_waddr;
	logic [PW-1:0] p_wdata;
	logic [7:0]    h_wdata;
	always_comb begin
		p_we    = (ctl.cmd == lzad_pkg::CMD_CLR) || (ctl.cmd == lzad_pkg::CMD_UPD);
		p_waddr = (ctl.cmd == lzad_pkg::CMD_CLR) ? clr_q : idx;
		p_wdata = (ctl.cmd == lzad_pkg::CMD_CLR) ? lzad_pkg::PROB_INIT : (lt ? p_inc : p_dec);
		h_we    = (ctl.cmd == lzad_pkg::CMD_COPY)
			|| ((ctl.cmd == lzad_pkg::CMD_APPLY) && (phase_q == lzad_pkg::PH_LIT) && lit_t[8]);
		h_wdata = (ctl.cmd == lzad_pkg::CMD_COPY) ? h_rd : lit_t[7:0];
		f_we    = (ctl.cmd == lzad_pkg::CMD_PUSH) && (cnt_q != FIFO_FULL);
	end

	lzad_ram #(.WIDTH(PW), .DEPTH(lzad_pkg::NUM_PROBS)) u_prob (
		.clk(clk), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
		.rd_addr(idx), .rd_data(p_rd)
	);

	lzad_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
		.clk(clk), .wr_en(h_we), .wr_addr(wpos_q), .wr_data(h_wdata),
		.rd_addr(h_raddr), .rd_data(h_rd)
	);

	lzad_ram #(.WIDTH(8), .DEPTH(INPUT_FIFO_DEPTH)) u_fifo (
		.clk(clk), .wr_en(f_we), .wr_addr(wr_q), .wr_data(byte_q),
		.rd_addr(rd_q), .rd_data(f_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= 1'b0;
			byte_q   <= '0;
			code_q   <= '0;
			range_q  <= '1;
			bound_q  <= '0;
			bit_q    <= 1'b0;
			phase_q  <= lzad_pkg::PH_PRE0;
			tree_q   <= '0;
			gval_q   <= '0;
			gctx_q   <= '0;
			extra_q  <= '0;
			last_q   <= '0;
			coff_q   <= '0;
			cleft_q  <= '0;
			after_q  <= 1'b0;
			wpos_q   <= '0;
			fill_q   <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			cnt_q    <= '0;
			clr_q    <= '0;
			done_q   <= 1'b0;
			rvalid_q <= 1'b0;
			rbyte_q  <= '0;
			rstat_q  <= lzad_pkg::STAT_OK;
			ov_q     <= 1'b0;
			oitem_q  <= '0;
		end else begin
			if (ov_q && !res_stall) begin
				ov_q <= 1'b0;
			end
			unique case (ctl.cmd)
				lzad_pkg::CMD_CLR: begin
					clr_q <= clr_q + 1'b1;
				end
				lzad_pkg::CMD_LATCH: begin
					op_q   <= in_item.opcode;
					byte_q <= in_item.in_byte;
				end
				lzad_pkg::CMD_PUSH: begin
					if (cnt_q == FIFO_FULL) begin
						// drop the byte
						rstat_q <= lzad_pkg::STAT_FULL;
					end else begin
						wr_q    <= wr_nxt;
						cnt_q   <= cnt_q + 1'b1;
						rstat_q <= lzad_pkg::STAT_OK;
					end
					rvalid_q <= 1'b0;
					rbyte_q  <= '0;
					done_q   <= 1'b1;
				end
				lzad_pkg::CMD_FIN_OK: begin
					rvalid_q <= 1'b0;
					rbyte_q  <= '0;
					rstat_q  <= lzad_pkg::STAT_OK;
					done_q   <= 1'b1;
				end
				lzad_pkg::CMD_STARVE: begin
					rvalid_q <= 1'b0;
					rbyte_q  <= '0;
					rstat_q  <= lzad_pkg::STAT_STARVED;
					done_q   <= 1'b1;
				end
				lzad_pkg::CMD_PRELOAD: begin
					code_q <= {code_q[23:0], f_rd};
					rd_q   <= rd_nxt;
					cnt_q  <= cnt_q - 1'b1;
					if (phase_q == lzad_pkg::PH_PRE3) begin
						phase_q <= lzad_pkg::PH_LIT;
						tree_q  <= 9'd1;
					end else begin
						phase_q <= lzad_pkg::phase_t'(phase_q + 4'd1);
					end
				end
				lzad_pkg::CMD_NORM: begin
					code_q  <= {code_q[23:0], f_rd};
					range_q <= {range_q[23:0], 8'h00};
					rd_q    <= rd_nxt;
					cnt_q   <= cnt_q - 1'b1;
				end
				lzad_pkg::CMD_MUL: begin
					bound_q <= prod[31:0];
				end
				lzad_pkg::CMD_UPD: begin
					if (lt) begin
						range_q <= bound_q;
						bit_q   <= 1'b0;
					end else begin
						code_q  <= code_q - bound_q;
						range_q <= range_q - bound_q;
						bit_q   <= 1'b1;
					end
				end
				lzad_pkg::CMD_APPLY: begin
					case (phase_q) inside
						lzad_pkg::PH_CODE: begin
							if (!bit_q) begin
								phase_q <= lzad_pkg::PH_LIT;
								tree_q  <= 9'd1;
							end else if (after_q) begin
								gctx_q  <= 8'd1;
								gval_q  <= 32'd1;
								phase_q <= lzad_pkg::PH_G0A;
							end else begin
								phase_q <= lzad_pkg::PH_PREV;
							end
						end
						lzad_pkg::PH_LIT: begin
							tree_q <= lit_t;
							if (lit_t[8]) begin
								rvalid_q <= 1'b1;
								rbyte_q  <= lit_t[7:0];
								rstat_q  <= lzad_pkg::STAT_OK;
								done_q   <= 1'b1;
								wpos_q   <= wpos_nxt;
								fill_q   <= fill_nxt;
								after_q  <= 1'b0;
								phase_q  <= lzad_pkg::PH_CODE;
							end
						end
						lzad_pkg::PH_PREV: begin
							gctx_q <= 8'd1;
							gval_q <= 32'd1;
							if (bit_q) begin
								coff_q  <= last_q;
								extra_q <= 2'd0;
								phase_q <= lzad_pkg::PH_G1A;
							end else begin
								phase_q <= lzad_pkg::PH_G0A;
							end
						end
						lzad_pkg::PH_G0A, lzad_pkg::PH_G1A: begin
							gctx_q  <= ngc;
							phase_q <= lzad_pkg::phase_t'(phase_q + 4'd1);
						end
						lzad_pkg::PH_G0B, lzad_pkg::PH_G1B: begin
							gval_q <= ngv;
							gctx_q <= ngc;
							if (ngc[1]) begin
								phase_q <= lzad_pkg::phase_t'(phase_q - 4'd1);
							end else if (phase_q == lzad_pkg::PH_G0B) begin
								if (ngv == 32'd0) begin
									// end marker
									phase_q  <= lzad_pkg::PH_END;
									rvalid_q <= 1'b0;
									rbyte_q  <= '0;
									rstat_q  <= lzad_pkg::STAT_OK;
									done_q   <= 1'b1;
								end else begin
									coff_q  <= ngv - 32'd2;
									tree_q  <= 9'd1;
									phase_q <= lzad_pkg::PH_LOW;
								end
							end else begin
								last_q  <= coff_q;
								after_q <= 1'b1;
								if (bad_ofs) begin
									cleft_q  <= '0;
									phase_q  <= lzad_pkg::PH_CODE;
									rvalid_q <= 1'b0;
									rbyte_q  <= '0;
									rstat_q  <= lzad_pkg::STAT_BAD_OFS;
									done_q   <= 1'b1;
								end else begin
									cleft_q <= ncl;
									phase_q <= (ncl != 32'd0) ? lzad_pkg::PH_COPY
										: lzad_pkg::PH_CODE;
								end
							end
						end
						lzad_pkg::PH_LOW: begin
							tree_q <= {tree_q[7:0], bit_q};
							if (tree_q[3]) begin
								phase_q <= lzad_pkg::PH_LOWFIN;
							end
						end
						default: begin
							phase_q <= phase_q;
						end
					endcase
				end
				lzad_pkg::CMD_LOWFIN: begin
					coff_q  <= noff;
					extra_q <= nextra;
					gctx_q  <= 8'd1;
					gval_q  <= 32'd1;
					phase_q <= lzad_pkg::PH_G1A;
				end
				lzad_pkg::CMD_COPY: begin
					rvalid_q <= 1'b1;
					rbyte_q  <= h_rd;
					rstat_q  <= lzad_pkg::STAT_OK;
					done_q   <= 1'b1;
					wpos_q   <= wpos_nxt;
					fill_q   <= fill_nxt;
					cleft_q  <= cleft_q - 32'd1;
					if (cleft_q == 32'd1) begin
						phase_q <= lzad_pkg::PH_CODE;
					end
				end
				lzad_pkg::CMD_OUT: begin
					ov_q               <= 1'b1;
					oitem_q.out_byte   <= rbyte_q;
					oitem_q.out_valid  <= rvalid_q;
					oitem_q.stream_end <= (phase_q == lzad_pkg::PH_END);
					oitem_q.status     <= rstat_q;
					done_q             <= 1'b0;
				end
				default: begin
					done_q <= done_q;
				end
			endcase
		end
	end

	always_comb begin
		sts.clr_done   = (clr_q == PROB_LAST);
		sts.op_pull    = op_q;
		sts.need_norm  = (range_q[31:24] == 8'h00);
		sts.fifo_empty = (cnt_q == '0);
		sts.done       = done_q;
		sts.out_free   = !ov_q || !res_stall;
		case (phase_q) inside
			lzad_pkg::PH_PRE0, lzad_pkg::PH_PRE1, lzad_pkg::PH_PRE2, lzad_pkg::PH_PRE3:
				sts.act = lzad_pkg::ACT_PRELOAD;
			lzad_pkg::PH_LOWFIN: sts.act = lzad_pkg::ACT_LOWFIN;
			lzad_pkg::PH_COPY:   sts.act = lzad_pkg::ACT_COPY;
			lzad_pkg::PH_END:    sts.act = lzad_pkg::ACT_END;
			default:             sts.act = lzad_pkg::ACT_BIT;
		endcase
	end

	assign res_valid = ov_q;
	assign res_item  = oitem_q;

endmodule

@@ rtl/lz_arithmetic_depacker_unit.sv @@
// LZ depacker with an adaptive binary arithmetic decoder. A push beat stores one
// compressed byte in the input FIFO, or drops it when full; a pull beat decodes
// until one output byte, a starve point, a bad offset or the end marker. Each
// coded bit passes through the shared probability RAM and 21x12 multiplier loop
// (dispatch, optional renormalize, multiply, update, apply); a copied byte is
// read from the history RAM. Results leave through an output register, one beat
// per accepted input beat. After reset the block clears its 803 probabilities to
// their start value, one entry a cycle, and stalls its input while it does so.
module lz_arithmetic_depacker_unit #(
	parameter int WINDOW_BYTES     = 65536,
	parameter int INPUT_FIFO_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lzad_pkg::in_item_t  in_item,
	output logic                res_valid,
	input  logic                res_stall,
	output lzad_pkg::out_item_t res_item
);

	lzad_pkg::ctl_t ctl;
	lzad_pkg::sts_t sts;

	lzad_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .ctl(ctl)
	);

	lzad_dp #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.INPUT_FIFO_DEPTH(INPUT_FIFO_DEPTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .in_item(in_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
	);

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import lzad_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_item;
	logic       res_valid;
	logic       res_stall = 1'b0;
	out_item_t  res_item;

	lz_arithmetic_depacker_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
	);

	always #5 clk = ~clk;

	int        n_err = 0;
	bit        calm = 1'b0;
	int        hold_left = 0;
	out_item_t expected_beats[$];

	// ---------------- decoder state (predictor) ----------------
	logic [31:0] code_r, range_r;
	logic [11:0] prob[NUM_PROBS];
	logic [7:0]  hist[65536];
	logic [31:0] wpos, fill, last_ofs, copy_left, copy_ofs;
	logic [31:0] tree_ctx, gval, extra;
	logic [7:0]  gctx;
	bit          aftm;
	phase_t      ph;
	logic [7:0]  fifo_q[$];

	// ---------------- encoder state (stimulus shaping) ----------------
	logic [7:0]  packed_bytes[$];
	int          sptr = 0;
	logic [63:0] e_low;
	logic [31:0] e_range;
	logic [7:0]  e_cache;
	int          e_csize;
	bit          e_first;
	logic [11:0] eprob[NUM_PROBS];
	bit          e_aftm;
	logic [31:0] e_last, e_fill;

	task automatic report_mismatch(string msg);
		n_err++;
		if (n_err <= 40)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic void decoder_reset();
		code_r = '0;
		range_r = '1;
		foreach (prob[i]) prob[i] = PROB_INIT;
		wpos = 0; fill = 0; last_ofs = 0; copy_left = 0; copy_ofs = 0;
		tree_ctx = 0; gval = 0; extra = 0; gctx = 0; aftm = 0;
		ph = PH_PRE0;
		fifo_q.delete();
	endfunction

	function automatic bit decode_bit(int unsigned idx, int unsigned mv, output bit b);
		logic [31:0] p, bound;
		logic [7:0]  x;
		b = 1'b0;
		if (range_r < 32'h0100_0000) begin
			if (fifo_q.size() == 0) return 1'b0;
			x = fifo_q.pop_front();
			code_r = {code_r[23:0], x};
			range_r = range_r << 8;
		end
		if (idx >= NUM_PROBS) idx = 0;
		p = prob[idx];
		bound = (range_r >> 11) * p;
		if (code_r < bound) begin
			range_r = bound;
			p = p + ((32'd2048 - p) >> mv);
			b = 1'b0;
		end else begin
			code_r = code_r - bound;
			range_r = range_r - bound;
			p = p - (p >> mv);
			b = 1'b1;
		end
		prob[idx] = p[11:0];
		return 1'b1;
	endfunction

	function automatic void store_history(logic [7:0] v);
		hist[wpos[15:0]] = v;
		wpos = (wpos + 1) & 32'hFFFF;
		if (fill < 65536) fill++;
	endfunction

	// decode until one byte, a starve point, a bad offset or the end marker
	function automatic logic [1:0] decode_pull(output logic [7:0] ob, output bit ov);
		bit          b;
		logic [7:0]  x;
		int unsigned base;
		ob = '0;
		ov = 1'b0;
		forever begin
			case (ph)
			PH_PRE0, PH_PRE1, PH_PRE2, PH_PRE3: begin
				if (fifo_q.size() == 0) return STAT_STARVED;
				x = fifo_q.pop_front();
				code_r = {code_r[23:0], x};
				if (ph == PH_PRE3) begin
					ph = PH_LIT;
					tree_ctx = 1;
				end else begin
					ph = phase_t'(ph + 1);
				end
			end
			PH_CODE: begin
				if (!decode_bit(M_CODE + aftm, 5, b)) return STAT_STARVED;
				if (!b) begin
					ph = PH_LIT;
					tree_ctx = 1;
				end else if (aftm) begin
					gctx = 1; gval = 1; ph = PH_G0A;
				end else begin
					ph = PH_PREV;
				end
			end
			PH_LIT: begin
				while (tree_ctx < 256) begin
					if (!decode_bit(M_LIT + tree_ctx, 4, b)) return STAT_STARVED;
					tree_ctx = tree_ctx * 2 + b;
				end
				ob = tree_ctx[7:0];
				ov = 1'b1;
				store_history(ob);
				aftm = 1'b0;
				ph = PH_CODE;
				return STAT_OK;
			end
			PH_PREV: begin
				if (!decode_bit(M_PREV, 5, b)) return STAT_STARVED;
				gctx = 1; gval = 1;
				if (b) begin
					copy_ofs = last_ofs;
					extra = 0;
					ph = PH_G1A;
				end else begin
					ph = PH_G0A;
				end
			end
			PH_G0A, PH_G1A: begin
				base = (ph == PH_G0A) ? M_G0 : M_G1;
				if (!decode_bit(base + gctx, 5, b)) return STAT_STARVED;
				gctx = {gctx[6:0], b};
				ph = phase_t'(ph + 1);
			end
			PH_G0B, PH_G1B: begin
				base = (ph == PH_G0B) ? M_G0 : M_G1;
				if (!decode_bit(base + gctx, 5, b)) return STAT_STARVED;
				gval = gval * 2 + b;
				gctx = {gctx[6:0], gval[0]};
				if (gctx[1]) begin
					ph = phase_t'(ph - 1);
				end else if (ph == PH_G0B) begin
					if (gval == 0) begin
						ph = PH_END;
						return STAT_OK;
					end
					copy_ofs = gval - 2;
					tree_ctx = 1;
					ph = PH_LOW;
				end else begin
					last_ofs = copy_ofs;
					aftm = 1'b1;
					copy_left = extra + gval;
					if (copy_ofs == 0 || copy_ofs > fill) begin
						copy_left = 0;
						ph = PH_CODE;
						return STAT_BAD_OFS;
					end
					ph = (copy_left != 0) ? PH_COPY : PH_CODE;
				end
			end
			PH_LOW: begin
				base = M_LOW + ((copy_ofs != 0) ? 16 : 0);
				while (tree_ctx < 16) begin
					if (!decode_bit(base + tree_ctx, 5, b)) return STAT_STARVED;
					tree_ctx = tree_ctx * 2 + b;
				end
				copy_ofs = (copy_ofs << 4) + (tree_ctx - 16) + 1;
				extra = 0;
				if (!copy_ofs[31]) begin
					if (copy_ofs >= FAR_OFFSET) extra++;
					if (copy_ofs >= NEAR_OFFSET) extra++;
				end
				gctx = 1; gval = 1;
				ph = PH_G1A;
			end
			PH_COPY: begin
				ob = hist[(wpos - copy_ofs) & 32'hFFFF];
				ov = 1'b1;
				store_history(ob);
				copy_left--;
				if (copy_left == 0) ph = PH_CODE;
				return STAT_OK;
			end
			default: begin
				ph = PH_END;
				return STAT_OK;
			end
			endcase
		end
	endfunction

	function automatic out_item_t decoder_step(in_item_t it);
		out_item_t  r;
		logic [7:0] ob;
		bit         ov;
		r = '0;
		if (!it.opcode) begin
			if (fifo_q.size() >= 16) r.status = STAT_FULL;
			else fifo_q.push_back(it.in_byte);
		end else if (ph != PH_END) begin
			r.status = decode_pull(ob, ov);
			r.out_valid = ov;
			r.out_byte = ov ? ob : 8'h00;
		end
		r.stream_end = (ph == PH_END);
		return r;
	endfunction

	// ---------------- range encoder that builds the compressed stream ----------------
	function automatic void enc_shift_low();
		logic [7:0] tmp;
		if (e_low < 64'hFF00_0000 || e_low >= 64'h1_0000_0000) begin
			tmp = e_cache;
			do begin
				if (e_first) e_first = 1'b0;
				else packed_bytes.push_back(tmp + e_low[32]);
				tmp = 8'hFF;
				e_csize--;
			end while (e_csize != 0);
			e_cache = e_low[31:24];
		end
		e_csize++;
		e_low = {32'h0, e_low[23:0], 8'h00};
	endfunction

	function automatic void enc_bit(int unsigned idx, int unsigned mv, bit b);
		logic [31:0] p, bound;
		p = eprob[idx];
		bound = (e_range >> 11) * p;
		if (!b) begin
			e_range = bound;
			p = p + ((32'd2048 - p) >> mv);
		end else begin
			e_low = e_low + bound;
			e_range = e_range - bound;
			p = p - (p >> mv);
		end
		eprob[idx] = p[11:0];
		while (e_range < 32'h0100_0000) begin
			e_range = e_range << 8;
			enc_shift_low();
		end
	endfunction

	// n value bits below the implied leading one, each behind a "more" flag
	function automatic void enc_gamma(int unsigned base, logic [31:0] bits, int n);
		logic [7:0] ctx;
		bit         a;
		ctx = 1;
		for (int i = n - 1; i >= 0; i--) begin
			a = (i != 0);
			enc_bit(base + ctx, 5, a);
			ctx = {ctx[6:0], a};
			enc_bit(base + ctx, 5, bits[i]);
			ctx = {ctx[6:0], bits[i]};
		end
	endfunction

	function automatic void enc_gamma_value(int unsigned base, logic [31:0] v);
		int n;
		n = 0;
		while ((v >> (n + 1)) != 0) n++;
		enc_gamma(base, v, n);
	endfunction

	function automatic void tok_lit(logic [7:0] v);
		logic [8:0] ctx;
		enc_bit(M_CODE + e_aftm, 5, 1'b0);
		ctx = 1;
		for (int i = 7; i >= 0; i--) begin
			enc_bit(M_LIT + ctx, 4, v[i]);
			ctx = {ctx[7:0], v[i]};
		end
		if (e_fill < 65536) e_fill++;
		e_aftm = 1'b0;
	endfunction

	// length part of a match; a zero length wraps the gamma value to zero
	function automatic void tok_len(logic [31:0] ofs, logic [31:0] gv, logic [31:0] len, bit zl);
		if (zl) enc_gamma(M_G1, 32'h0, 32);
		else enc_gamma_value(M_G1, gv);
		e_last = ofs;
		e_aftm = 1'b1;
		if (ofs != 0 && ofs <= e_fill) begin
			e_fill = e_fill + len;
			if (e_fill > 65536) e_fill = 65536;
		end
	endfunction

	function automatic void tok_new(logic [31:0] ofs, logic [31:0] len, bit zl);
		logic [31:0] hi, ex;
		hi = (ofs - 1) >> 4;
		enc_bit(M_CODE + e_aftm, 5, 1'b1);
		if (!e_aftm) enc_bit(M_PREV, 5, 1'b0);
		enc_gamma_value(M_G0, hi + 2);
		begin
			logic [4:0] ctx;
			logic [3:0] lo;
			lo = ofs - 1;
			ctx = 1;
			for (int i = 3; i >= 0; i--) begin
				enc_bit(M_LOW + ((hi != 0) ? 16 : 0) + ctx, 5, lo[i]);
				ctx = {ctx[3:0], lo[i]};
			end
		end
		ex = 0;
		if (!ofs[31]) ex = (ofs >= FAR_OFFSET) + (ofs >= NEAR_OFFSET);
		tok_len(ofs, len - ex, zl ? 32'h0 : len, zl);
	endfunction

	function automatic void tok_rep(logic [31:0] len);
		enc_bit(M_CODE + e_aftm, 5, 1'b1);
		enc_bit(M_PREV, 5, 1'b1);
		tok_len(e_last, len, len, 1'b0);
	endfunction

	function automatic void build_stream();
		int          r;
		logic [31:0] ofs, ex, lim;
		e_low = 0; e_range = '1; e_cache = 0; e_csize = 1; e_first = 1'b1;
		foreach (eprob[i]) eprob[i] = PROB_INIT;
		e_aftm = 0; e_last = 0; e_fill = 0;
		// directed: extremes, repeat with no offset yet, overlap, bad and wrapping offsets
		tok_lit(8'h00);
		tok_rep(2);
		tok_lit(8'hFF);
		tok_lit(8'h5A);
		tok_new(1, 5, 0);
		tok_new(3, 2, 0);
		tok_lit(8'hA5);
		tok_rep(3);
		tok_lit(8'h81);
		tok_new(1000, 4, 0);
		tok_new(0, 2, 0);
		tok_new(32'h8000_0001, 3, 0);
		tok_new(3000, 5, 0);
		tok_new(2, 0, 1);
		tok_lit(8'h7E);
		for (int t = 0; t < 95; t++) begin
			r = $urandom_range(99);
			if (r < 45 || e_fill == 0) begin
				tok_lit($urandom_range(255));
			end else if (r < 75) begin
				lim = (e_fill < 400) ? e_fill : 400;
				ofs = $urandom_range(lim, 1);
				ex = (ofs >= FAR_OFFSET) + (ofs >= NEAR_OFFSET);
				if ($urandom_range(9) == 0) tok_new(ofs, ex + $urandom_range(120, 30), 0);
				else tok_new(ofs, ex + $urandom_range(12, 2), 0);
			end else if (r < 88 && !e_aftm) begin
				tok_rep($urandom_range(10, 2));
			end else if (r < 88) begin
				tok_lit($urandom_range(255));
			end else begin
				tok_new(e_fill + $urandom_range(5000, 1), 4, 0);
			end
		end
		// end marker: offset gamma that wraps to zero
		enc_bit(M_CODE + e_aftm, 5, 1'b1);
		if (!e_aftm) enc_bit(M_PREV, 5, 1'b0);
		enc_gamma(M_G0, 32'h0, 32);
		for (int i = 0; i < 5; i++) enc_shift_low();
	endfunction

	// ---------------- drivers and checker ----------------
	task automatic send_item(in_item_t it);
		if (!calm && $urandom_range(99) < 33) begin
			in_valid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 33);
		end
		in_valid = 1'b1;
		in_item = it;
		do @(posedge clk); while (in_stall);
		expected_beats.push_back(decoder_step(it));
		@(negedge clk);
	endtask

	task automatic send_pull();
		in_item_t it;
		it.opcode = 1'b1;
		it.in_byte = $urandom_range(255);
		send_item(it);
	endtask

	task automatic stream_step();
		in_item_t it;
		if (sptr < packed_bytes.size() && fifo_q.size() < 16 && $urandom_range(99) < 55) begin
			it.opcode = 1'b0;
			it.in_byte = packed_bytes[sptr];
			sptr++;
			send_item(it);
		end else begin
			send_pull();
		end
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			res_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
		end
	end

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_beats.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				e = expected_beats.pop_front();
				if (res_item.out_byte !== e.out_byte)
					report_mismatch($sformatf("out_byte %h, want %h", res_item.out_byte, e.out_byte));
				if (res_item.out_valid !== e.out_valid)
					report_mismatch($sformatf("out_valid %b, want %b",
						res_item.out_valid, e.out_valid));
				if (res_item.stream_end !== e.stream_end)
					report_mismatch($sformatf("stream_end %b, want %b",
						res_item.stream_end, e.stream_end));
				if (res_item.status !== e.status)
					report_mismatch($sformatf("status %0d, want %0d", res_item.status, e.status));
			end
		end
	end

	// ---------------- tests ----------------
	task automatic test_preload_starve();
		send_pull();
		send_pull();
	endtask

	task automatic test_stream_decode(int upto);
		while (sptr < upto) stream_step();
	endtask

	task automatic test_backpressure();
		@(posedge clk);
		hold_left = 400;
		@(negedge clk);
		for (int i = 0; i < 50; i++) stream_step();
	endtask

	task automatic test_stream_end();
		int tries;
		tries = 0;
		while (sptr < packed_bytes.size()) stream_step();
		while (ph != PH_END && tries < 80) begin
			send_pull();
			tries++;
		end
		send_pull();
	endtask

	task automatic test_push_when_full();
		in_item_t it;
		for (int i = 0; i < 20; i++) begin
			it.opcode = 1'b0;
			it.in_byte = $urandom_range(255);
			send_item(it);
		end
		send_pull();
	endtask

	initial begin
		int settle;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		decoder_reset();
		build_stream();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_preload_starve();
		test_stream_decode(packed_bytes.size() / 3);
		test_backpressure();
		calm = 1'b1;
		test_stream_decode(packed_bytes.size() * 2 / 3);
		calm = 1'b0;
		test_stream_end();
		test_push_when_full();
		in_valid = 1'b0;

		settle = 0;
		while (expected_beats.size() != 0 && settle < 100000) begin
			@(posedge clk);
			settle++;
		end
		repeat (200) @(posedge clk);
		if (n_err == 0 && expected_beats.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
